>>> rtl/core/rau_pkg.sv
// ----------------------------------------------------------------------------
// rau_pkg: shared definitions for the rational arithmetic unit
// Operation codes, status codes, default widths and unit status type.
// ----------------------------------------------------------------------------
package rau_pkg;

  localparam int OPERAND_WIDTH_DEF = 16;
  localparam int REQ_TYPE_W        = 3;

  localparam logic [REQ_TYPE_W-1:0] OP_ADD      = 3'd0;
  localparam logic [REQ_TYPE_W-1:0] OP_SUB      = 3'd1;
  localparam logic [REQ_TYPE_W-1:0] OP_MUL      = 3'd2;
  localparam logic [REQ_TYPE_W-1:0] OP_DIV      = 3'd3;
  localparam logic [REQ_TYPE_W-1:0] OP_SIMPLIFY = 3'd4;

  localparam logic ST_OK        = 1'b0;
  localparam logic ST_ZERO_ZERO = 1'b1;

  typedef struct packed {
    logic busy;
    logic done;
  } unit_stat_t;

endpackage

>>> rtl/core/rational_arithmetic_unit.sv
// ----------------------------------------------------------------------------
// rational_arithmetic_unit: add, subtract, multiply, divide, simplify fractions
// Sequencer around a shared multiplier, a binary gcd unit and a divider.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel in_valid/in_ready carries one transaction: an operation
//   code and two fractions A = a_num/a_den, B = b_num/b_den. The result
//   channel out_valid/out_ready returns one fraction and a status bit per
//   transaction, in order. Results are 2*OPERAND_WIDTH+1 bits and never wrap.
//   Add, subtract, multiply and divide run three products through the one
//   registered multiplier. Simplify runs the binary gcd (one shift or
//   subtract per cycle) and then two divisions on the one divider.
//   Unused codes and simplify of 0/0 go straight to the done state, from
//   which out_valid is registered.
//   One transaction is in work at a time; in_ready is high only when idle.
//   A finished result sits in the output register while the next
//   transaction is accepted; if the receiver stalls, the sequencer holds
//   its next result until the output register is free.
//   Synchronous active-low reset returns to idle and drops out_valid.
// ----------------------------------------------------------------------------
module rational_arithmetic_unit #(
  parameter int OPERAND_WIDTH = rau_pkg::OPERAND_WIDTH_DEF
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_valid,
  output logic                              in_ready,
  input  logic [rau_pkg::REQ_TYPE_W-1:0]    in_req_type,
  input  logic signed [OPERAND_WIDTH-1:0]   in_a_num,
  input  logic signed [OPERAND_WIDTH-1:0]   in_a_den,
  input  logic signed [OPERAND_WIDTH-1:0]   in_b_num,
  input  logic signed [OPERAND_WIDTH-1:0]   in_b_den,
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic signed [2*OPERAND_WIDTH:0]   out_res_num,
  output logic signed [2*OPERAND_WIDTH:0]   out_res_den,
  output logic                              out_status
);
  import rau_pkg::*;

  localparam int W  = OPERAND_WIDTH;
  localparam int RW = 2*OPERAND_WIDTH+1;

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_MUL  = 3'd1;
  localparam logic [2:0] S_GCD  = 3'd2;
  localparam logic [2:0] S_DIVN = 3'd3;
  localparam logic [2:0] S_DIVD = 3'd4;
  localparam logic [2:0] S_DONE = 3'd5;

  logic [2:0]            state_r;
  logic [2:0]            state_nxt;
  logic [REQ_TYPE_W-1:0] op_r;
  logic signed [W-1:0]   an_r;
  logic signed [W-1:0]   ad_r;
  logic signed [W-1:0]   bn_r;
  logic signed [W-1:0]   bd_r;
  logic [1:0]            step_r;
  logic signed [RW-1:0]  num_r;
  logic signed [RW-1:0]  den_r;
  logic                  st_r;
  logic [W-1:0]          g_r;
  logic [W-1:0]          qn_r;
  logic                  out_valid_r;
  logic signed [RW-1:0]  out_num_r;
  logic signed [RW-1:0]  out_den_r;
  logic                  out_st_r;

  logic                  accept;
  logic                  in_zero_zero;
  logic                  in_op_used;
  logic                  out_load;
  logic [W-1:0]          in_an_mag;
  logic [W-1:0]          in_ad_mag;
  logic [W-1:0]          an_mag;
  logic [W-1:0]          ad_mag;

  logic signed [W-1:0]   mul_a;
  logic signed [W-1:0]   mul_b;
  logic signed [2*W-1:0] prod;
  logic signed [RW-1:0]  prod_ext;

  logic                  gcd_start;
  logic [W-1:0]          gcd_g;
  unit_stat_t            gcd_stat;

  logic                  div_start;
  logic [W-1:0]          div_dividend;
  logic [W-1:0]          div_divisor;
  logic [W-1:0]          div_quo;
  unit_stat_t            div_stat;

  logic [RW-1:0]         qn_ext;
  logic [RW-1:0]         qd_ext;

  assign in_ready     = (state_r == S_IDLE);
  assign accept       = in_valid && in_ready;
  assign in_zero_zero = (in_a_num == '0) && (in_a_den == '0);
  assign in_op_used   = (in_req_type == OP_ADD) || (in_req_type == OP_SUB) ||
                        (in_req_type == OP_MUL) || (in_req_type == OP_DIV);
  assign out_load     = (state_r == S_DONE) && (!out_valid_r || out_ready);

  assign in_an_mag = in_a_num[W-1] ? W'(-in_a_num) : W'(in_a_num);
  assign in_ad_mag = in_a_den[W-1] ? W'(-in_a_den) : W'(in_a_den);
  assign an_mag    = an_r[W-1] ? W'(-an_r) : W'(an_r);
  assign ad_mag    = ad_r[W-1] ? W'(-ad_r) : W'(ad_r);

  always_comb begin
    mul_a = '0;
    mul_b = '0;
    unique case (step_r)
      2'd0: begin
        mul_a = an_r;
        mul_b = (op_r == OP_MUL) ? bn_r : bd_r;
      end
      2'd1: begin
        if ((op_r == OP_ADD) || (op_r == OP_SUB)) begin
          mul_a = ad_r;
          mul_b = bn_r;
        end
      end
      2'd2: begin
        mul_a = ad_r;
        mul_b = (op_r == OP_DIV) ? bn_r : bd_r;
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  rau_mul #(.OPERAND_WIDTH(W)) u_mul (
    .clk    (clk),
    .op_a   (mul_a),
    .op_b   (mul_b),
    .prod_r (prod)
  );

  assign prod_ext = RW'(prod);

  assign gcd_start = accept && (in_req_type == OP_SIMPLIFY) && !in_zero_zero;

  rau_gcd #(.OPERAND_WIDTH(W)) u_gcd (
    .clk   (clk),
    .rst_n (rst_n),
    .start (gcd_start),
    .mag_u (in_an_mag),
    .mag_v (in_ad_mag),
    .g_r   (gcd_g),
    .stat  (gcd_stat)
  );

  assign div_start    = ((state_r == S_GCD) && gcd_stat.done) ||
                        ((state_r == S_DIVN) && div_stat.done);
  assign div_dividend = (state_r == S_GCD) ? an_mag : ad_mag;
  assign div_divisor  = (state_r == S_GCD) ? gcd_g : g_r;

  rau_div #(.OPERAND_WIDTH(W)) u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (div_dividend),
    .divisor  (div_divisor),
    .quo_r    (div_quo),
    .stat     (div_stat)
  );

  assign qn_ext = RW'(qn_r);
  assign qd_ext = RW'(div_quo);

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: begin
        if (accept) begin
          priority if (in_op_used) begin
            state_nxt = S_MUL;
          end else if ((in_req_type == OP_SIMPLIFY) && !in_zero_zero) begin
            state_nxt = S_GCD;
          end else begin
            state_nxt = S_DONE;
          end
        end
      end
      S_MUL: begin
        if (step_r == 2'd3) begin
          state_nxt = S_DONE;
        end
      end
      S_GCD: begin
        if (gcd_stat.done) begin
          state_nxt = S_DIVN;
        end
      end
      S_DIVN: begin
        if (div_stat.done) begin
          state_nxt = S_DIVD;
        end
      end
      S_DIVD: begin
        if (div_stat.done) begin
          state_nxt = S_DONE;
        end
      end
      S_DONE: begin
        if (out_load) begin
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      step_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (accept) begin
        step_r <= '0;
      end else if (state_r == S_MUL) begin
        step_r <= step_r + 1'b1;
      end
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      op_r  <= in_req_type;
      an_r  <= in_a_num;
      ad_r  <= in_a_den;
      bn_r  <= in_b_num;
      bd_r  <= in_b_den;
      num_r <= '0;
      den_r <= '0;
      st_r  <= ((in_req_type == OP_SIMPLIFY) && in_zero_zero) ? ST_ZERO_ZERO : ST_OK;
    end
    if (state_r == S_MUL) begin
      unique case (step_r)
        2'd1: num_r <= prod_ext;
        2'd2: num_r <= (op_r == OP_SUB) ? num_r - prod_ext : num_r + prod_ext;
        2'd3: den_r <= prod_ext;
        default: num_r <= num_r;
      endcase
    end
    if ((state_r == S_GCD) && gcd_stat.done) begin
      g_r <= gcd_g;
    end
    if ((state_r == S_DIVN) && div_stat.done) begin
      qn_r <= div_quo;
    end
    if ((state_r == S_DIVD) && div_stat.done) begin
      num_r <= an_r[W-1] ? -qn_ext : qn_ext;
      den_r <= ad_r[W-1] ? -qd_ext : qd_ext;
    end
    if (out_load) begin
      out_num_r <= num_r;
      out_den_r <= den_r;
      out_st_r  <= st_r;
    end
  end

  assign out_valid   = out_valid_r;
  assign out_res_num = out_num_r;
  assign out_res_den = out_den_r;
  assign out_status  = out_st_r;

endmodule

>>> rtl/core/rau_mul.sv
// ----------------------------------------------------------------------------
// rau_mul: registered signed multiplier
// One signed product per cycle, registered from the operands.
// ----------------------------------------------------------------------------
module rau_mul #(
  parameter int OPERAND_WIDTH = rau_pkg::OPERAND_WIDTH_DEF
) (
  input  logic                            clk,
  input  logic signed [OPERAND_WIDTH-1:0] op_a,
  input  logic signed [OPERAND_WIDTH-1:0] op_b,
  output logic signed [2*OPERAND_WIDTH-1:0] prod_r
);

  always_ff @(posedge clk) begin
    prod_r <= op_a * op_b;
  end

endmodule

>>> rtl/core/rau_div.sv
// ----------------------------------------------------------------------------
// rau_div: iterative unsigned divider
// Restoring division, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module rau_div #(
  parameter int OPERAND_WIDTH = rau_pkg::OPERAND_WIDTH_DEF
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     start,
  input  logic [OPERAND_WIDTH-1:0] dividend,
  input  logic [OPERAND_WIDTH-1:0] divisor,
  output logic [OPERAND_WIDTH-1:0] quo_r,
  output rau_pkg::unit_stat_t      stat
);
  import rau_pkg::*;

  localparam int W     = OPERAND_WIDTH;
  localparam int CNT_W = $clog2(W);

  logic [W-1:0]     rem_r;
  logic [W-1:0]     dsr_r;
  logic [CNT_W-1:0] cnt_r;
  logic             busy_r;
  logic             done_r;
  logic [W:0]       shifted;
  logic [W:0]       diff;
  logic             ge;

  assign shifted = {rem_r, quo_r[W-1]};
  assign ge      = shifted >= {1'b0, dsr_r};
  assign diff    = shifted - {1'b0, dsr_r};

  assign stat.busy = busy_r;
  assign stat.done = done_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
      end else if (busy_r) begin
        cnt_r <= cnt_r + 1'b1;
        if (cnt_r == CNT_W'(W-1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem_r <= '0;
      quo_r <= dividend;
      dsr_r <= divisor;
    end else if (busy_r) begin
      rem_r <= ge ? diff[W-1:0] : shifted[W-1:0];
      quo_r <= {quo_r[W-2:0], ge};
    end
  end

endmodule

>>> rtl/core/rau_gcd.sv
// ----------------------------------------------------------------------------
// rau_gcd: binary greatest common divisor
// One shift or subtract per cycle on two magnitudes; gcd(x,0) = x.
// ----------------------------------------------------------------------------
module rau_gcd #(
  parameter int OPERAND_WIDTH = rau_pkg::OPERAND_WIDTH_DEF
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     start,
  input  logic [OPERAND_WIDTH-1:0] mag_u,
  input  logic [OPERAND_WIDTH-1:0] mag_v,
  output logic [OPERAND_WIDTH-1:0] g_r,
  output rau_pkg::unit_stat_t      stat
);
  import rau_pkg::*;

  localparam int W   = OPERAND_WIDTH;
  localparam int K_W = $clog2(W);

  logic [W-1:0]   x_r;
  logic [W-1:0]   y_r;
  logic [K_W-1:0] k_r;
  logic           busy_r;
  logic           done_r;
  logic           fin;

  assign fin = (x_r == '0) || (y_r == '0) || (x_r == y_r);

  assign stat.busy = busy_r;
  assign stat.done = done_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
      end else if (busy_r && fin) begin
        busy_r <= 1'b0;
        done_r <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      x_r <= mag_u;
      y_r <= mag_v;
      k_r <= '0;
    end else if (busy_r) begin
      if (fin) begin
        priority if (x_r == '0) begin
          g_r <= y_r;
        end else if (y_r == '0) begin
          g_r <= x_r;
        end else begin
          g_r <= x_r << k_r;
        end
      end else begin
        priority if (!x_r[0] && !y_r[0]) begin
          x_r <= x_r >> 1;
          y_r <= y_r >> 1;
          k_r <= k_r + 1'b1;
        end else if (!x_r[0]) begin
          x_r <= x_r >> 1;
        end else if (!y_r[0]) begin
          y_r <= y_r >> 1;
        end else if (x_r > y_r) begin
          x_r <= x_r - y_r;
        end else begin
          y_r <= y_r - x_r;
        end
      end
    end
  end

endmodule

>>> rtl/core/rau_checker.sv
// ----------------------------------------------------------------------------
// rau_checker: port-level assertions for the rational arithmetic unit
// Watches the handshakes and result fields; bound to the top level.
// ----------------------------------------------------------------------------
module rau_checker #(
  parameter int OPERAND_WIDTH = rau_pkg::OPERAND_WIDTH_DEF
) (
  input logic                            clk,
  input logic                            rst_n,
  input logic                            in_valid,
  input logic                            in_ready,
  input logic                            out_valid,
  input logic                            out_ready,
  input logic signed [2*OPERAND_WIDTH:0] out_res_num,
  input logic signed [2*OPERAND_WIDTH:0] out_res_den,
  input logic                            out_status
);
  import rau_pkg::*;

  a_busy_after_accept: assert property (
    @(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready
  ) else $error("in_ready high right after an accepted transaction");

  a_no_instant_result: assert property (
    @(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !$rose(out_valid)
  ) else $error("result appeared one cycle after acceptance");

  a_zero_zero_flag: assert property (
    @(posedge clk) disable iff (!rst_n)
    out_valid && (out_status == ST_ZERO_ZERO) |-> (out_res_num == '0) && (out_res_den == '0)
  ) else $error("zero-over-zero flag with nonzero result");

  a_out_hold: assert property (
    @(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_res_num) &&
                                $stable(out_res_den) && $stable(out_status)
  ) else $error("stalled result changed or dropped");

endmodule

bind rational_arithmetic_unit rau_checker #(.OPERAND_WIDTH(OPERAND_WIDTH)) u_rau_checker (.*);

>>> test/fraction_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fraction_checker: result prediction and comparison for the rational unit
// Watches both channels at the rising clock edge. Each accepted request
// transaction is turned into the fraction the unit must return. Each accepted
// result transaction is compared field by field against the oldest one.
// ----------------------------------------------------------------------------
module fraction_checker
  import rau_pkg::*;
#(
  parameter int W = OPERAND_WIDTH_DEF
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      in_valid,
  input  logic                      in_ready,
  input  logic [REQ_TYPE_W-1:0]     in_req_type,
  input  logic signed [W-1:0]       in_a_num,
  input  logic signed [W-1:0]       in_a_den,
  input  logic signed [W-1:0]       in_b_num,
  input  logic signed [W-1:0]       in_b_den,
  input  logic                      out_valid,
  input  logic                      out_ready,
  input  logic signed [2*W:0]       out_res_num,
  input  logic signed [2*W:0]       out_res_den,
  input  logic                      out_status,
  output int                        mismatches,
  output int                        pending
);

  localparam int RW = 2 * W + 1;

  typedef struct packed {
    logic signed [RW-1:0] num;
    logic signed [RW-1:0] den;
    logic                 status;
  } fraction_t;

  fraction_t expected_fractions[$];
  int        fail_count = 0;
  int        queued = 0;

  assign mismatches = fail_count;
  assign pending    = queued;

  function automatic fraction_t predict_fraction(
    input logic [REQ_TYPE_W-1:0] op,
    input logic signed [W-1:0]   an,
    input logic signed [W-1:0]   ad,
    input logic signed [W-1:0]   bn,
    input logic signed [W-1:0]   bd
  );
    longint    san, sad, sbn, sbd;
    longint    n, d, x, y, t;
    fraction_t r;
    san = an;
    sad = ad;
    sbn = bn;
    sbd = bd;
    n = 0;
    d = 0;
    r.status = ST_OK;
    case (op)
      OP_ADD: begin
        n = san * sbd + sad * sbn;
        d = sad * sbd;
      end
      OP_SUB: begin
        n = san * sbd - sad * sbn;
        d = sad * sbd;
      end
      OP_MUL: begin
        n = san * sbn;
        d = sad * sbd;
      end
      OP_DIV: begin
        n = san * sbd;
        d = sad * sbn;
      end
      OP_SIMPLIFY: begin
        x = (san < 0) ? -san : san;
        y = (sad < 0) ? -sad : sad;
        while (y != 0) begin
          t = x % y;
          x = y;
          y = t;
        end
        if (x == 0) begin
          r.status = ST_ZERO_ZERO;
        end else begin
          n = san / x;
          d = sad / x;
        end
      end
      default: ;
    endcase
    r.num = n[RW-1:0];
    r.den = d[RW-1:0];
    return r;
  endfunction

  task automatic report_mismatch(input string msg);
    $display("%0t ns: fraction error: %s", $time, msg);
    fail_count++;
  endtask

  always @(posedge clk) begin
    fraction_t want;
    if (rst_n) begin
      if (in_valid && in_ready) begin
        expected_fractions.push_back(
          predict_fraction(in_req_type, in_a_num, in_a_den, in_b_num, in_b_den));
      end
      if (out_valid && out_ready) begin
        if (expected_fractions.size() == 0) begin
          report_mismatch($sformatf("unexpected result %0d/%0d status %0b",
                                    out_res_num, out_res_den, out_status));
        end else begin
          want = expected_fractions.pop_front();
          if (out_res_num !== want.num)
            report_mismatch($sformatf("res_num got %0d expected %0d",
                                      out_res_num, want.num));
          if (out_res_den !== want.den)
            report_mismatch($sformatf("res_den got %0d expected %0d",
                                      out_res_den, want.den));
          if (out_status !== want.status)
            report_mismatch($sformatf("status got %0b expected %0b",
                                      out_status, want.status));
        end
      end
      queued = expected_fractions.size();
    end
  end

endmodule

>>> test/tb_rational_arithmetic_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_rational_arithmetic_unit: stimulus and verdict for the rational unit
// Drives directed corner fractions for every operation, then random requests
// mixing full-range, small, extreme and factor-rich operands, with random
// gaps on both channels, a stretch without gaps and one long result stall.
// ----------------------------------------------------------------------------
module tb_rational_arithmetic_unit;
  import rau_pkg::*;

  localparam int W          = OPERAND_WIDTH_DEF;
  localparam int N_RANDOM   = 1500;
  localparam int HOLD_LEN   = 400;
  localparam int WATCHDOG   = 3000;
  localparam int TAIL       = 200;

  localparam logic signed [W-1:0] MAXV = {1'b0, {(W-1){1'b1}}};
  localparam logic signed [W-1:0] MINV = {1'b1, {(W-1){1'b0}}};

  logic                    clk = 1'b0;
  logic                    rst_n = 1'b0;
  logic                    in_valid = 1'b0;
  logic                    in_ready;
  logic [REQ_TYPE_W-1:0]   in_req_type = OP_ADD;
  logic signed [W-1:0]     in_a_num = '0;
  logic signed [W-1:0]     in_a_den = '0;
  logic signed [W-1:0]     in_b_num = '0;
  logic signed [W-1:0]     in_b_den = '0;
  logic                    out_valid;
  logic                    out_ready = 1'b0;
  logic signed [2*W:0]     out_res_num;
  logic signed [2*W:0]     out_res_den;
  logic                    out_status;

  int   mismatches;
  int   pending;
  int   idle_cycles = 0;
  logic steady = 1'b0;
  logic hold_req = 1'b0;

  rational_arithmetic_unit #(.OPERAND_WIDTH(W)) dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready), .in_req_type(in_req_type),
    .in_a_num(in_a_num), .in_a_den(in_a_den),
    .in_b_num(in_b_num), .in_b_den(in_b_den),
    .out_valid(out_valid), .out_ready(out_ready),
    .out_res_num(out_res_num), .out_res_den(out_res_den),
    .out_status(out_status)
  );

  fraction_checker #(.W(W)) u_checker (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready), .in_req_type(in_req_type),
    .in_a_num(in_a_num), .in_a_den(in_a_den),
    .in_b_num(in_b_num), .in_b_den(in_b_den),
    .out_valid(out_valid), .out_ready(out_ready),
    .out_res_num(out_res_num), .out_res_den(out_res_den),
    .out_status(out_status),
    .mismatches(mismatches), .pending(pending)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // stall the result channel at random; hold off for a long stretch on request
  initial begin
    @(posedge rst_n);
    forever begin
      @(negedge clk);
      if (hold_req) begin
        out_ready = 1'b0;
        repeat (HOLD_LEN) @(negedge clk);
        hold_req = 1'b0;
      end
      out_ready = steady || ($urandom_range(0, 99) >= 10);
    end
  end

  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
    if (idle_cycles >= WATCHDOG) begin
      $display("rational_arithmetic_unit: mismatch");
      $finish;
    end
  end

  task automatic send_request(
    input logic [REQ_TYPE_W-1:0] op,
    input logic signed [W-1:0]   an,
    input logic signed [W-1:0]   ad,
    input logic signed [W-1:0]   bn,
    input logic signed [W-1:0]   bd
  );
    while (!steady && $urandom_range(0, 99) < 10) begin
      in_valid = 1'b0;
      @(negedge clk);
    end
    in_valid    = 1'b1;
    in_req_type = op;
    in_a_num    = an;
    in_a_den    = ad;
    in_b_num    = bn;
    in_b_den    = bd;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    @(negedge clk);
  endtask

  function automatic logic signed [W-1:0] pick_operand();
    int v;
    case ($urandom_range(0, 9))
      0, 1, 2, 3, 4: v = $urandom;
      5, 6:          v = int'($urandom_range(0, 40)) - 20;
      7: begin
        case ($urandom_range(0, 3))
          0:       v = MINV;
          1:       v = MAXV;
          2:       v = 0;
          default: v = -1;
        endcase
      end
      default: begin
        v = int'($urandom_range(1, 127)) * (1 << $urandom_range(0, 8));
        if ($urandom_range(0, 1)) v = -v;
      end
    endcase
    return v[W-1:0];
  endfunction

  initial begin
    logic [REQ_TYPE_W-1:0] op;
    int                    sel;
    logic signed [W-1:0]   scale;

    repeat (9) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    send_request(OP_ADD, 1, 2, 1, 3);
    send_request(OP_ADD, MINV, MINV, MINV, MINV);
    send_request(OP_ADD, MAXV, MAXV, MAXV, MAXV);
    send_request(OP_ADD, 1, 0, 2, 0);
    send_request(OP_SUB, MINV, MAXV, MAXV, MINV);
    send_request(OP_SUB, -1, -1, -1, -1);
    send_request(OP_SUB, 0, 0, 0, 0);
    send_request(OP_MUL, MINV, MINV, MINV, MINV);
    send_request(OP_MUL, MAXV, -1, MINV, 1);
    send_request(OP_MUL, 0, 5, 7, 0);
    send_request(OP_DIV, MINV, MAXV, MINV, MINV);
    send_request(OP_DIV, 5, 3, 0, 7);
    send_request(OP_DIV, MAXV, MINV, MAXV, -1);
    send_request(OP_SIMPLIFY, 0, 0, 3, 4);
    send_request(OP_SIMPLIFY, 12, 0, 0, 0);
    send_request(OP_SIMPLIFY, 0, -7, 0, 0);
    send_request(OP_SIMPLIFY, MINV, MINV, 0, 0);
    send_request(OP_SIMPLIFY, MINV, MAXV, 0, 0);
    send_request(OP_SIMPLIFY, MINV, 0, 0, 0);
    send_request(OP_SIMPLIFY, -36, 48, MAXV, MINV);
    send_request(OP_SIMPLIFY, MAXV, -1, 0, 0);
    send_request(3'd5, 9, 4, -3, 2);
    send_request(3'd6, MINV, MAXV, MINV, MAXV);
    send_request(3'd7, -1, -1, -1, -1);

    hold_req = 1'b1;
    for (int i = 0; i < N_RANDOM; i++) begin
      steady = (i >= 600) && (i < 900);
      sel = $urandom_range(0, 19);
      if (sel < 12) op = REQ_TYPE_W'(sel % 4);
      else if (sel < 18) op = OP_SIMPLIFY;
      else op = REQ_TYPE_W'($urandom_range(5, 7));
      if (op == OP_SIMPLIFY && $urandom_range(0, 1)) begin
        // share a common factor so the reduction has work to do
        scale = W'($urandom_range(1, 181));
        send_request(op, W'(scale * (int'($urandom_range(0, 362)) - 181)),
                     W'(scale * (int'($urandom_range(0, 362)) - 181)),
                     pick_operand(), pick_operand());
      end else begin
        send_request(op, pick_operand(), pick_operand(), pick_operand(), pick_operand());
      end
    end
    steady   = 1'b0;
    in_valid = 1'b0;

    while (pending != 0 || hold_req) @(posedge clk);
    repeat (TAIL) @(posedge clk);

    if (mismatches == 0) begin
      $display("rational_arithmetic_unit: match");
    end else begin
      $display("rational_arithmetic_unit: mismatch");
    end
    $finish;
  end

endmodule
